### hw/rtl/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types and constants of the packet header checker: beat layouts,
// status and result codes, register indexes and the result push bundle.
// ----------------------------------------------------------------------------
package phc_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int HDR_CNT_W    = 5;
   localparam int OUT_DEPTH    = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TRUNCATED  = 3'd1,
      ST_BAD_MAGIC  = 3'd2,
      ST_BAD_VER    = 3'd3,
      ST_BAD_TYPE   = 3'd4,
      ST_LEN_MISM   = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      REG_MAGIC     = 2'd0,
      REG_VERSION   = 2'd1,
      REG_TYPE_LOW  = 2'd2,
      REG_TYPE_HIGH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [15:0] packet_type;
      logic [31:0] sequence_number;
      logic [31:0] frame_number;
      logic [31:0] payload_length;
   } rsp_beat_type;

   typedef struct packed {
      logic [31:0] magic_value;
      logic [15:0] protocol_version;
      logic [15:0] type_low;
      logic [15:0] type_high;
   } cfg_type;

   // up to two result beats produced by one accepted input beat
   typedef struct packed {
      logic [1:0]   count;
      rsp_beat_type first;
      rsp_beat_type second;
   } res_push_type;

endpackage

### hw/rtl/phc_csr.sv
// ----------------------------------------------------------------------------
// phc_csr
// Configuration registers: magic word, protocol version and the accepted
// packet type range, written and read over the register port.
// ----------------------------------------------------------------------------
module phc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [phc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [phc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [phc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output phc_pkg::cfg_type                   cfg
);

   phc_pkg::cfg_type       cfg_ff;
   phc_pkg::cfg_type       cfg_in;
   phc_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   assign pready  = 1'b1;
   assign reg_idx = phc_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            phc_pkg::REG_MAGIC:     cfg_in.magic_value      = pwdata;
            phc_pkg::REG_VERSION:   cfg_in.protocol_version = pwdata[15:0];
            phc_pkg::REG_TYPE_LOW:  cfg_in.type_low         = pwdata[15:0];
            phc_pkg::REG_TYPE_HIGH: cfg_in.type_high        = pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         phc_pkg::REG_MAGIC:     prdata = cfg_ff.magic_value;
         phc_pkg::REG_VERSION:   prdata = {16'd0, cfg_ff.protocol_version};
         phc_pkg::REG_TYPE_LOW:  prdata = {16'd0, cfg_ff.type_low};
         phc_pkg::REG_TYPE_HIGH: prdata = {16'd0, cfg_ff.type_high};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/phc_core.sv
// ----------------------------------------------------------------------------
// phc_core
// Per-packet state: header assembly, payload counting and the header checks.
// Forms up to two result beats for each accepted input beat.
// ----------------------------------------------------------------------------
module phc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  phc_pkg::req_beat_type in_beat,
   input  phc_pkg::cfg_type      cfg,
   output phc_pkg::res_push_type push
);

   logic [phc_pkg::HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in, hdr_cnt_upd;
   logic [31:0] magic_ff,  magic_in,  magic_upd;
   logic [15:0] ver_ff,    ver_in,    ver_upd;
   logic [15:0] ptype_ff,  ptype_in,  ptype_upd;
   logic [31:0] len_ff,    len_in,    len_upd;
   logic [31:0] seq_ff,    seq_in,    seq_upd;
   logic [31:0] frame_ff,  frame_in,  frame_upd;
   logic [31:0] pay_cnt_ff, pay_cnt_in, pay_cnt_upd;

   logic                   in_header;
   logic                   hdr_ok;
   logic                   fwd;
   phc_pkg::status_type    st;
   phc_pkg::rsp_beat_type  pay_res;
   phc_pkg::rsp_beat_type  st_res;

   assign in_header = hdr_cnt_ff < phc_pkg::HDR_CNT_W'(phc_pkg::HEADER_BYTES);
   assign hdr_ok    = (magic_ff == cfg.magic_value) && (ver_ff == cfg.protocol_version) &&
                      (ptype_ff >= cfg.type_low) && (ptype_ff <= cfg.type_high);
   assign fwd       = !in_header && hdr_ok;

   // header byte placement and payload count
   always_comb begin
      hdr_cnt_upd = hdr_cnt_ff;
      magic_upd   = magic_ff;
      ver_upd     = ver_ff;
      ptype_upd   = ptype_ff;
      len_upd     = len_ff;
      seq_upd     = seq_ff;
      frame_upd   = frame_ff;
      pay_cnt_upd = pay_cnt_ff;
      if (in_header) begin
         hdr_cnt_upd = hdr_cnt_ff + 1'b1;
         case (hdr_cnt_ff) inside
            [5'd0:5'd3]:   magic_upd[{hdr_cnt_ff[1:0], 3'b000} +: 8] = in_beat.byte_value;
            [5'd4:5'd5]:   ver_upd[{hdr_cnt_ff[0], 3'b000} +: 8]     = in_beat.byte_value;
            [5'd6:5'd7]:   ptype_upd[{hdr_cnt_ff[0], 3'b000} +: 8]   = in_beat.byte_value;
            [5'd8:5'd11]:  len_upd[{hdr_cnt_ff[1:0], 3'b000} +: 8]   = in_beat.byte_value;
            [5'd12:5'd15]: seq_upd[{hdr_cnt_ff[1:0], 3'b000} +: 8]   = in_beat.byte_value;
            default:       frame_upd[{hdr_cnt_ff[1:0], 3'b000} +: 8] = in_beat.byte_value;
         endcase
      end else if (pay_cnt_ff != '1) begin
         pay_cnt_upd = pay_cnt_ff + 1'b1;
      end
   end

   // end-of-packet status in priority order
   always_comb begin
      if (hdr_cnt_upd < phc_pkg::HDR_CNT_W'(phc_pkg::HEADER_BYTES)) begin
         st = phc_pkg::ST_TRUNCATED;
      end else if (magic_upd != cfg.magic_value) begin
         st = phc_pkg::ST_BAD_MAGIC;
      end else if (ver_upd != cfg.protocol_version) begin
         st = phc_pkg::ST_BAD_VER;
      end else if ((ptype_upd < cfg.type_low) || (ptype_upd > cfg.type_high)) begin
         st = phc_pkg::ST_BAD_TYPE;
      end else if ((pay_cnt_upd == '1) || (pay_cnt_upd != len_upd)) begin
         st = phc_pkg::ST_LEN_MISM;
      end else begin
         st = phc_pkg::ST_OK;
      end
   end

   always_comb begin
      pay_res              = '0;
      pay_res.result_kind  = phc_pkg::KIND_PAYLOAD;
      pay_res.payload_byte = in_beat.byte_value;
      pay_res.status       = phc_pkg::ST_OK;

      st_res                 = '0;
      st_res.result_kind     = phc_pkg::KIND_STATUS;
      st_res.status          = st;
      st_res.packet_type     = ptype_upd;
      st_res.sequence_number = seq_upd;
      st_res.frame_number    = frame_upd;
      st_res.payload_length  = len_upd;

      push.count  = 2'd0;
      push.first  = fwd ? pay_res : st_res;
      push.second = st_res;
      if (in_accept) begin
         push.count = {1'b0, fwd} + {1'b0, in_beat.last_byte};
      end
   end

   // the last byte returns all packet state to zero
   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      magic_in   = magic_ff;
      ver_in     = ver_ff;
      ptype_in   = ptype_ff;
      len_in     = len_ff;
      seq_in     = seq_ff;
      frame_in   = frame_ff;
      pay_cnt_in = pay_cnt_ff;
      if (in_accept) begin
         if (in_beat.last_byte) begin
            hdr_cnt_in = '0;
            magic_in   = '0;
            ver_in     = '0;
            ptype_in   = '0;
            len_in     = '0;
            seq_in     = '0;
            frame_in   = '0;
            pay_cnt_in = '0;
         end else begin
            hdr_cnt_in = hdr_cnt_upd;
            magic_in   = magic_upd;
            ver_in     = ver_upd;
            ptype_in   = ptype_upd;
            len_in     = len_upd;
            seq_in     = seq_upd;
            frame_in   = frame_upd;
            pay_cnt_in = pay_cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff <= '0;
         magic_ff   <= '0;
         ver_ff     <= '0;
         ptype_ff   <= '0;
         len_ff     <= '0;
         seq_ff     <= '0;
         frame_ff   <= '0;
         pay_cnt_ff <= '0;
      end else begin
         hdr_cnt_ff <= hdr_cnt_in;
         magic_ff   <= magic_in;
         ver_ff     <= ver_in;
         ptype_ff   <= ptype_in;
         len_ff     <= len_in;
         seq_ff     <= seq_in;
         frame_ff   <= frame_in;
         pay_cnt_ff <= pay_cnt_in;
      end
   end

endmodule

### hw/rtl/phc_outq.sv
// ----------------------------------------------------------------------------
// phc_outq
// Result queue: takes up to two result beats per cycle and hands one beat
// per cycle to the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module phc_outq #(
   parameter int DEPTH = phc_pkg::OUT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  phc_pkg::res_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output phc_pkg::rsp_beat_type rsp_beat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   phc_pkg::rsp_beat_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign room      = count_ff <= CNT_W'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_beat  = mem[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_nx = ptr_next(wr_ptr_ff);

   always_comb begin
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = ptr_next(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_nx] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/packet_header_checker_unit.sv
// ----------------------------------------------------------------------------
// packet_header_checker_unit
// Streaming packet header checker: assembles a 20-byte little-endian header,
// forwards payload bytes of packets whose header passes and closes each
// packet with one status beat.
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle while req_stall is low, and its results
// are written into a small result queue in the same cycle; a result is held
// there until earlier beats have left the rsp port. A byte that is both
// payload and the last byte of the packet yields two result beats; the rsp
// port drains one beat per cycle while rsp_stall is low. req_stall rises while
// the queue cannot hold two more beats. Registers are to be written only while
// no packet byte is in flight; the block itself does not enforce this.
module packet_header_checker_unit #(
   parameter int OUT_DEPTH = phc_pkg::OUT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  phc_pkg::req_beat_type             req_beat,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output phc_pkg::rsp_beat_type             rsp_beat,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [phc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [phc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [phc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   phc_pkg::cfg_type      cfg;
   phc_pkg::res_push_type push;
   logic                  room;
   logic                  req_accept;

   assign req_stall  = !room;
   assign req_accept = req_valid && !req_stall;

   phc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   phc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_beat   (req_beat),
      .cfg       (cfg),
      .push      (push)
   );

   phc_outq #(
      .DEPTH (OUT_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule
